FILE: src/imq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imq_pkg;

    localparam int NUM_CORES   = 4;
    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_PAYLOAD = 64;

    localparam int CORE_W = $clog2(NUM_CORES);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int PAY_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int FILL_W = $clog2(MAX_PAYLOAD + 1);
    localparam int SLOT_W = CORE_W + PTR_W;
    localparam int PAY_AW = SLOT_W + PAY_W;
    localparam int HDR_W  = 16 + FILL_W;

    localparam logic [2:0] DEST_BCAST = 3'd4;

    typedef enum logic [1:0] {
        FUNC_SEND  = 2'd0,
        FUNC_RECV  = 2'd1,
        FUNC_COUNT = 2'd2
    } func_t;

    typedef logic [CORE_W-1:0] core_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [FILL_W-1:0] fill_t;

    typedef struct packed {
        logic [7:0]  sender;
        logic [7:0]  mtype;
        fill_t       len;
    } hdr_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  got_sender;
        logic [7:0]  got_type;
        logic [6:0]  got_len;
        logic [7:0]  got_byte;
        logic        is_last;
        logic [5:0]  queue_count;
        logic        nonempty;
    } res_t;

endpackage

`default_nettype wire

FILE: src/imq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface imq_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [1:0]  requester_core;
    logic [2:0]  target_core;
    logic [7:0]  origin_id;
    logic [7:0]  msg_kind;
    logic [7:0]  msg_len;
    logic [7:0]  data_byte;
    logic        byte_last;

    modport source (
        output valid, func, requester_core, target_core, origin_id, msg_kind,
               msg_len, data_byte, byte_last,
        input  ready
    );
    modport sink (
        input  valid, func, requester_core, target_core, origin_id, msg_kind,
               msg_len, data_byte, byte_last,
        output ready
    );
endinterface

interface imq_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [7:0]  got_sender;
    logic [7:0]  got_type;
    logic [6:0]  got_len;
    logic [7:0]  got_byte;
    logic        is_last;
    logic [5:0]  queue_count;
    logic        nonempty;

    modport source (
        output valid, status, got_sender, got_type, got_len, got_byte, is_last,
               queue_count, nonempty,
        input  ready
    );
    modport sink (
        input  valid, status, got_sender, got_type, got_len, got_byte, is_last,
               queue_count, nonempty,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/imq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module imq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/intercore_mailbox_queues_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake    payload
// cmd      in   valid/ready  func, core ids, header fields, data_byte, byte_last
// rsp      out  valid/ready  status, received header and byte, is_last, count, nonempty
//
// one request at a time; a send byte that is not last is staged, cmd stays ready
// last send byte: S_PICK takes each target core in turn; a full queue fails it, len 0
// commits only the header, else S_COPY copies the payload from staging to payload RAM
// receive: S_RX_HDR, then max(n,1) bytes, one per cycle off the payload memory
// unless rsp stalls; count, failed receive and unknown func use S_PUSH; rsp stalls hold
// the sequencer; reset clears every register but runs no memory clearing pass

module intercore_mailbox_queues_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    imq_cmd_if.sink   cmd,
    imq_rsp_if.source rsp
);

    import imq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_COPY,
        S_RX_HDR,
        S_RX_DATA,
        S_PUSH
    } state_t;

    state_t                state_reg, state_next;
    ptr_t                  wp_reg [NUM_CORES];
    ptr_t                  wp_next [NUM_CORES];
    ptr_t                  rp_reg [NUM_CORES];
    ptr_t                  rp_next [NUM_CORES];
    fill_t                 fill_reg, fill_next;
    logic [NUM_CORES-1:0]  mask_reg, mask_next;
    logic                  st_reg, st_next;
    logic [7:0]            snd_reg, snd_next;
    logic [7:0]            typ_reg, typ_next;
    logic [7:0]            len_reg, len_next;
    core_t                 cmt_core_reg, cmt_core_next;
    ptr_t                  cmt_wp_reg, cmt_wp_next;
    fill_t                 copy_idx_reg, copy_idx_next;
    logic                  wr_pend_reg, wr_pend_next;
    logic [PAY_W-1:0]      wr_idx_reg, wr_idx_next;
    core_t                 rx_core_reg, rx_core_next;
    ptr_t                  rx_rp_reg, rx_rp_next;
    fill_t                 rx_n_reg, rx_n_next;
    fill_t                 k_reg, k_next;
    res_t                  pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_res_reg, out_res_next;

    logic                  accept;
    logic                  out_free;
    logic                  req_ok;
    core_t                 req_core;
    core_t                 pick_core;
    core_t                 ptr_idx;
    ptr_t                  ptr_wp;
    ptr_t                  ptr_rp;
    logic                  q_full;
    logic                  push;
    res_t                  push_res;
    hdr_t                  hdr_rd;

    logic                  stage_we;
    logic [PAY_W-1:0]      stage_waddr;
    logic [7:0]            stage_wdata;
    logic                  stage_re;
    logic [PAY_W-1:0]      stage_raddr;
    logic [7:0]            stage_rdata;

    logic                  hdr_we;
    logic [SLOT_W-1:0]     hdr_waddr;
    logic [HDR_W-1:0]      hdr_wdata;
    logic                  hdr_re;
    logic [SLOT_W-1:0]     hdr_raddr;
    logic [HDR_W-1:0]      hdr_rdata;

    logic                  pay_we;
    logic [PAY_AW-1:0]     pay_waddr;
    logic [7:0]            pay_wdata;
    logic                  pay_re;
    logic [PAY_AW-1:0]     pay_raddr;
    logic [7:0]            pay_rdata;

    imq_ram #(.WIDTH(8), .DEPTH(2 ** PAY_W)) u_stage_ram (
        .clk   (clk),
        .we    (stage_we),
        .waddr (stage_waddr),
        .wdata (stage_wdata),
        .re    (stage_re),
        .raddr (stage_raddr),
        .rdata (stage_rdata)
    );

    imq_ram #(.WIDTH(HDR_W), .DEPTH(2 ** SLOT_W)) u_hdr_ram (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (hdr_waddr),
        .wdata (hdr_wdata),
        .re    (hdr_re),
        .raddr (hdr_raddr),
        .rdata (hdr_rdata)
    );

    imq_ram #(.WIDTH(8), .DEPTH(2 ** PAY_AW)) u_pay_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .re    (pay_re),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req_ok    = int'(cmd.requester_core) < NUM_CORES;
    assign req_core  = core_t'(cmd.requester_core);
    assign hdr_rd    = hdr_t'(hdr_rdata);

    // lowest pending broadcast target
    always_comb
    begin
        pick_core = '0;
        for (int i = NUM_CORES - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick_core = core_t'(i);
            end
        end
    end

    assign ptr_idx = (state_reg == S_PICK) ? pick_core : req_core;
    assign ptr_wp  = wp_reg[ptr_idx];
    assign ptr_rp  = rp_reg[ptr_idx];
    assign q_full  = (ptr_wp + 1'b1) == ptr_rp;

    always_comb
    begin
        logic [8:0]  n9;
        fill_t       rx_cnt;
        ptr_t        occ;

        state_next    = state_reg;
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        fill_next     = fill_reg;
        mask_next     = mask_reg;
        st_next       = st_reg;
        snd_next      = snd_reg;
        typ_next      = typ_reg;
        len_next      = len_reg;
        cmt_core_next = cmt_core_reg;
        cmt_wp_next   = cmt_wp_reg;
        copy_idx_next = copy_idx_reg;
        wr_pend_next  = wr_pend_reg;
        wr_idx_next   = wr_idx_reg;
        rx_core_next  = rx_core_reg;
        rx_rp_next    = rx_rp_reg;
        rx_n_next     = rx_n_reg;
        k_next        = k_reg;
        pend_next     = pend_reg;

        stage_we    = 1'b0;
        stage_waddr = fill_reg[PAY_W-1:0];
        stage_wdata = cmd.data_byte;
        stage_re    = 1'b0;
        stage_raddr = copy_idx_reg[PAY_W-1:0];

        hdr_we      = 1'b0;
        hdr_waddr   = {pick_core, ptr_wp};
        hdr_wdata   = hdr_t'{sender: snd_reg, mtype: typ_reg, len: fill_t'(len_reg)};
        hdr_re      = 1'b0;
        hdr_raddr   = {req_core, ptr_rp};

        pay_we      = wr_pend_reg;
        pay_waddr   = {cmt_core_reg, cmt_wp_reg, wr_idx_reg};
        pay_wdata   = (fill_t'(wr_idx_reg) < fill_reg) ? stage_rdata : 8'd0;
        pay_re      = 1'b0;
        pay_raddr   = {req_core, ptr_rp, {PAY_W{1'b0}}};

        push        = 1'b0;
        push_res    = '0;

        n9     = 9'(hdr_rd.len);
        rx_cnt = (rx_n_reg == '0) ? fill_t'(1) : rx_n_reg;
        occ    = ptr_wp - ptr_rp;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (func_t'(cmd.func))
                        FUNC_SEND:
                        begin
                            if (cmd.msg_len != 8'd0 && fill_reg < fill_t'(MAX_PAYLOAD))
                            begin
                                stage_we  = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                            if (cmd.byte_last)
                            begin
                                snd_next = cmd.origin_id;
                                typ_next = cmd.msg_kind;
                                len_next = cmd.msg_len;
                                st_next  = 1'b0;
                                for (int i = 0; i < NUM_CORES; i++)
                                begin
                                    if (cmd.target_core == DEST_BCAST)
                                    begin
                                        mask_next[i] = (i != int'(cmd.requester_core));
                                    end
                                    else
                                    begin
                                        mask_next[i] = (i == int'(cmd.target_core));
                                    end
                                end
                                if (cmd.target_core != DEST_BCAST
                                    && int'(cmd.target_core) >= NUM_CORES)
                                begin
                                    st_next = 1'b1;
                                end
                                // oversize payload fails every target
                                if (9'(cmd.msg_len) > 9'(MAX_PAYLOAD))
                                begin
                                    mask_next = '0;
                                    st_next   = 1'b1;
                                end
                                state_next = S_PICK;
                            end
                        end
                        FUNC_RECV:
                        begin
                            if (!req_ok || ptr_rp == ptr_wp)
                            begin
                                pend_next         = '0;
                                pend_next.status  = 1'b1;
                                pend_next.is_last = 1'b1;
                                state_next        = S_PUSH;
                            end
                            else
                            begin
                                hdr_re       = 1'b1;
                                pay_re       = 1'b1;
                                rx_core_next = req_core;
                                rx_rp_next   = ptr_rp;
                                len_next     = cmd.msg_len;
                                state_next   = S_RX_HDR;
                            end
                        end
                        FUNC_COUNT:
                        begin
                            pend_next         = '0;
                            pend_next.is_last = 1'b1;
                            if (req_ok)
                            begin
                                pend_next.queue_count = 6'(occ);
                                pend_next.nonempty    = (occ != '0);
                            end
                            state_next = S_PUSH;
                        end
                        default:
                        begin
                            pend_next         = '0;
                            pend_next.status  = 1'b1;
                            pend_next.is_last = 1'b1;
                            state_next        = S_PUSH;
                        end
                    endcase
                end
            end

            S_PICK:
            begin
                if (mask_reg == '0)
                begin
                    pend_next         = '0;
                    pend_next.status  = st_reg;
                    pend_next.is_last = 1'b1;
                    fill_next         = '0;
                    state_next        = S_PUSH;
                end
                else
                begin
                    mask_next[pick_core] = 1'b0;
                    if (q_full)
                    begin
                        st_next = 1'b1;
                    end
                    else
                    begin
                        hdr_we        = 1'b1;
                        cmt_core_next = pick_core;
                        cmt_wp_next   = ptr_wp;
                        if (len_reg == 8'd0)
                        begin
                            wp_next[pick_core] = ptr_wp + 1'b1;
                        end
                        else
                        begin
                            copy_idx_next = '0;
                            wr_pend_next  = 1'b0;
                            state_next    = S_COPY;
                        end
                    end
                end
            end

            S_COPY:
            begin
                // staging read in the cycle before its payload write
                if (9'(copy_idx_reg) < 9'(len_reg))
                begin
                    stage_re      = 1'b1;
                    copy_idx_next = copy_idx_reg + 1'b1;
                    wr_pend_next  = 1'b1;
                    wr_idx_next   = copy_idx_reg[PAY_W-1:0];
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg)
                    begin
                        wp_next[cmt_core_reg] = cmt_wp_reg + 1'b1;
                        state_next            = S_PICK;
                    end
                end
            end

            S_RX_HDR:
            begin
                if (n9 > 9'(MAX_PAYLOAD))
                begin
                    n9 = 9'(MAX_PAYLOAD);
                end
                if (9'(len_reg) < n9)
                begin
                    n9 = 9'(len_reg);
                end
                snd_next   = hdr_rd.sender;
                typ_next   = hdr_rd.mtype;
                rx_n_next  = fill_t'(n9);
                k_next     = '0;
                state_next = S_RX_DATA;
            end

            S_RX_DATA:
            begin
                if (out_free)
                begin
                    push                = 1'b1;
                    push_res.got_sender = snd_reg;
                    push_res.got_type   = typ_reg;
                    push_res.got_len    = 7'(rx_n_reg);
                    push_res.got_byte   = (rx_n_reg != '0) ? pay_rdata : 8'd0;
                    push_res.is_last    = (k_reg + 1'b1) == rx_cnt;
                    if ((k_reg + 1'b1) == rx_cnt)
                    begin
                        rp_next[rx_core_reg] = rx_rp_reg + 1'b1;
                        state_next           = S_IDLE;
                    end
                    else
                    begin
                        k_next    = k_reg + 1'b1;
                        pay_re    = 1'b1;
                        pay_raddr = {rx_core_reg, rx_rp_reg, PAY_W'(k_reg + 1'b1)};
                    end
                end
            end

            S_PUSH:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_res   = pend_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !rsp.ready;
        out_res_next   = out_res_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_res_next   = push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < NUM_CORES; i++)
            begin
                wp_reg[i] <= '0;
                rp_reg[i] <= '0;
            end
            fill_reg      <= '0;
            mask_reg      <= '0;
            st_reg        <= 1'b0;
            snd_reg       <= '0;
            typ_reg       <= '0;
            len_reg       <= '0;
            cmt_core_reg  <= '0;
            cmt_wp_reg    <= '0;
            copy_idx_reg  <= '0;
            wr_pend_reg   <= 1'b0;
            wr_idx_reg    <= '0;
            rx_core_reg   <= '0;
            rx_rp_reg     <= '0;
            rx_n_reg      <= '0;
            k_reg         <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            fill_reg      <= fill_next;
            mask_reg      <= mask_next;
            st_reg        <= st_next;
            snd_reg       <= snd_next;
            typ_reg       <= typ_next;
            len_reg       <= len_next;
            cmt_core_reg  <= cmt_core_next;
            cmt_wp_reg    <= cmt_wp_next;
            copy_idx_reg  <= copy_idx_next;
            wr_pend_reg   <= wr_pend_next;
            wr_idx_reg    <= wr_idx_next;
            rx_core_reg   <= rx_core_next;
            rx_rp_reg     <= rx_rp_next;
            rx_n_reg      <= rx_n_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            out_res_reg   <= out_res_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_res_reg.status;
    assign rsp.got_sender  = out_res_reg.got_sender;
    assign rsp.got_type    = out_res_reg.got_type;
    assign rsp.got_len     = out_res_reg.got_len;
    assign rsp.got_byte    = out_res_reg.got_byte;
    assign rsp.is_last     = out_res_reg.is_last;
    assign rsp.queue_count = out_res_reg.queue_count;
    assign rsp.nonempty    = out_res_reg.nonempty;

endmodule

`default_nettype wire
